[rtl/core/averaged_deadband_step_regulator_top_defines.svh]
// assertion macros for the averaged dead-band step regulator
`ifndef AVERAGED_DEADBAND_STEP_REGULATOR_TOP_DEFINES_SVH
`define AVERAGED_DEADBAND_STEP_REGULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define ADSR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/adsr_pkg.sv]
// shared types and constants for the averaged dead-band step regulator
package adsr_pkg;

   localparam int MV_W        = 12;
   localparam int SAMPLE_W    = 12;
   localparam int DUTY_W      = 16;
   localparam int STEP_W      = 16;
   localparam int CSR_ADDR_W  = 3;

   // x/5 as (x * 13108) >> 16, exact for x below 16384
   localparam int SCALE_RECIP = 13108;
   localparam int SCALE_SHIFT = 16;
   localparam int SCALE_OFFSET_MV = 28;

   localparam int DEADBAND_MV   = 10;
   localparam int GREEN_BAND_MV = 30;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd128;

   // register word index (paddr[2])
   localparam logic REG_SET_POINT    = 1'b0;
   localparam logic REG_INITIAL_STEP = 1'b1;

   typedef struct packed {
      logic             valid;
      logic [MV_W-1:0]  avg_mv;
   } adsr_avg_type;

endpackage

[rtl/core/adsr_window.sv]
// input register, millivolt scaling, window accumulation and averaging
module adsr_window #(
   parameter int WINDOW_SAMPLES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [adsr_pkg::SAMPLE_W-1:0]      in_sample,
   output adsr_pkg::adsr_avg_type             avg_bus,
   input  logic                               avg_ready
);

   localparam int CLOG_W    = $clog2(WINDOW_SAMPLES);
   localparam int CNT_W     = (CLOG_W > 0) ? CLOG_W : 1;
   localparam int SUM_W     = adsr_pkg::MV_W + CLOG_W;
   localparam int DIV_SHIFT = SUM_W + CLOG_W;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW_SAMPLES - 1);

   localparam int X4_W     = adsr_pkg::SAMPLE_W + 2;
   localparam int SCALE_W  = X4_W + 15;

   logic                          in_valid_ff, in_valid_in;
   logic [adsr_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic                          fin_valid_ff, fin_valid_in;
   logic [SUM_W-1:0]              fin_sum_ff, fin_sum_in;
   logic                          avg_valid_ff, avg_valid_in;
   logic [adsr_pkg::MV_W-1:0]     avg_ff, avg_in;

   logic                          fin_ready;
   logic                          take;
   logic                          last;
   logic                          fin_move;
   logic [X4_W-1:0]               x4;
   logic [SCALE_W-1:0]            scale_prod;
   logic [adsr_pkg::MV_W-1:0]     scaled_mv;
   logic [SUM_W-1:0]              sum_next;
   logic [PROD_W-1:0]             div_prod;

   assign in_ready  = !in_valid_ff || fin_ready;
   assign fin_ready = !fin_valid_ff || avg_ready;
   assign take      = in_valid_ff && fin_ready;
   assign last      = (count_ff == LAST_COUNT);
   assign fin_move  = fin_valid_ff && avg_ready;

   assign x4         = {sample_ff, 2'b00};
   assign scale_prod = SCALE_W'(x4) * SCALE_W'(adsr_pkg::SCALE_RECIP);
   assign scaled_mv  = scale_prod[adsr_pkg::SCALE_SHIFT +: adsr_pkg::MV_W]
                       + adsr_pkg::MV_W'(adsr_pkg::SCALE_OFFSET_MV);
   assign sum_next   = sum_ff + SUM_W'(scaled_mv);

   assign div_prod = PROD_W'(fin_sum_ff) * PROD_W'(RECIP_W'(DIV_RECIP));

   always_comb begin
      in_valid_in  = in_valid_ff;
      sample_in    = sample_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      fin_valid_in = fin_valid_ff;
      fin_sum_in   = fin_sum_ff;
      avg_valid_in = avg_valid_ff;
      avg_in       = avg_ff;

      if (in_ready) begin
         in_valid_in = in_valid;
         sample_in   = in_sample;
      end

      if (fin_move) begin
         fin_valid_in = 1'b0;
      end
      if (take) begin
         if (last) begin
            count_in     = '0;
            sum_in       = '0;
            fin_valid_in = 1'b1;
            fin_sum_in   = sum_next;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_next;
         end
      end

      if (avg_ready) begin
         avg_valid_in = fin_valid_ff;
         if (fin_valid_ff) begin
            avg_in = div_prod[DIV_SHIFT +: adsr_pkg::MV_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         fin_valid_ff <= 1'b0;
         avg_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         fin_valid_ff <= fin_valid_in;
         avg_valid_ff <= avg_valid_in;
      end
      sample_ff  <= sample_in;
      fin_sum_ff <= fin_sum_in;
      avg_ff     <= avg_in;
   end

   assign avg_bus.valid  = avg_valid_ff;
   assign avg_bus.avg_mv = avg_ff;

endmodule

[rtl/core/averaged_deadband_step_regulator_top.sv]
// a window's last sample passes the input, finished-sum, average and response registers in turn
// throughput: one sample per cycle unless rsp_tready holds a result back, one result per WINDOW_SAMPLES samples
// the rate is held by the output register and the elastic stages in front of it
// reset (synchronous): pipeline emptied, sum and count cleared, duty 0, led red
// reset also sets set point 0 and initial step and adjust step to 128
// top level of the averaged dead-band step regulator
`include "averaged_deadband_step_regulator_top_defines.svh"

module averaged_deadband_step_regulator_top #(
   parameter int WINDOW_SAMPLES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // [11:0] adc_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // [11:0] average_mv, [27:12] duty,
                                                         // [28] led_green
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [adsr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam logic signed [12:0] DEAD_S  = 13'(adsr_pkg::DEADBAND_MV);
   localparam logic signed [12:0] GREEN_S = 13'(adsr_pkg::GREEN_BAND_MV);

   logic [adsr_pkg::MV_W-1:0]    set_point_ff, set_point_in;
   logic [adsr_pkg::STEP_W-1:0]  init_step_ff, init_step_in;
   logic [adsr_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [adsr_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic                         led_ff, led_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [adsr_pkg::MV_W-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [adsr_pkg::DUTY_W-1:0]  rsp_duty_ff, rsp_duty_in;
   logic                         rsp_led_ff, rsp_led_in;

   adsr_pkg::adsr_avg_type       avg_bus;
   logic                         avg_ready;
   logic                         fire;
   logic                         csr_wr;
   logic                         step_wr;
   logic signed [12:0]           diff_s;
   logic                         in_dead;
   logic                         in_green;
   logic [adsr_pkg::DUTY_W:0]    raise_sum;
   logic [adsr_pkg::DUTY_W-1:0]  duty_adj;

   adsr_window #(
      .WINDOW_SAMPLES (WINDOW_SAMPLES)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata[adsr_pkg::SAMPLE_W-1:0]),
      .avg_bus   (avg_bus),
      .avg_ready (avg_ready)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign step_wr    = csr_wr && (csr_paddr[2] == adsr_pkg::REG_INITIAL_STEP);

   always_comb begin
      case (csr_paddr[2])
         adsr_pkg::REG_SET_POINT:    csr_prdata = 32'(set_point_ff);
         adsr_pkg::REG_INITIAL_STEP: csr_prdata = 32'(init_step_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // regulation
   assign avg_ready = !rsp_valid_ff || rsp_tready;
   assign fire      = avg_bus.valid && avg_ready;

   assign diff_s   = $signed({1'b0, avg_bus.avg_mv}) - $signed({1'b0, set_point_ff});
   assign in_dead  = (diff_s >= -DEAD_S) && (diff_s <= DEAD_S);
   assign in_green = (diff_s >= -GREEN_S) && (diff_s <= GREEN_S);
   assign raise_sum = {1'b0, duty_ff} + {1'b0, step_ff};

   always_comb begin
      if (diff_s > 13'sd0) begin
         duty_adj = (duty_ff > step_ff) ? (duty_ff - step_ff) : '0;
      end else begin
         duty_adj = raise_sum[adsr_pkg::DUTY_W] ? '1 : raise_sum[adsr_pkg::DUTY_W-1:0];
      end
   end

   always_comb begin
      set_point_in = set_point_ff;
      init_step_in = init_step_ff;
      step_in      = step_ff;
      duty_in      = duty_ff;
      led_in       = led_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_led_in   = rsp_led_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = avg_bus.avg_mv;
         rsp_duty_in  = duty_ff;
         rsp_led_in   = led_ff;
         if (!in_dead) begin
            duty_in     = duty_adj;
            led_in      = in_green;
            rsp_duty_in = duty_adj;
            rsp_led_in  = in_green;
            if (step_ff > adsr_pkg::STEP_W'(1)) begin
               step_in = step_ff >> 1;
            end
         end
      end

      if (csr_wr) begin
         case (csr_paddr[2])
            adsr_pkg::REG_SET_POINT: begin
               set_point_in = csr_pwdata[adsr_pkg::MV_W-1:0];
            end
            adsr_pkg::REG_INITIAL_STEP: begin
               init_step_in = csr_pwdata[adsr_pkg::STEP_W-1:0];
               step_in      = csr_pwdata[adsr_pkg::STEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff <= '0;
         init_step_ff <= adsr_pkg::STEP_RESET;
         step_ff      <= adsr_pkg::STEP_RESET;
         duty_ff      <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         set_point_ff <= set_point_in;
         init_step_ff <= init_step_in;
         step_ff      <= step_in;
         duty_ff      <= duty_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_avg_ff  <= rsp_avg_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_led_ff  <= rsp_led_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_led_ff, rsp_duty_ff, rsp_avg_ff};

   `ADSR_ASSERT_NEXT(duty_hold_a, !fire, $stable(duty_ff), "duty changed without a window result")
   `ADSR_ASSERT_NEXT(step_shrink_a, fire && !step_wr, step_ff <= $past(step_ff), "step grew on a window result")
   `ADSR_ASSERT_NEXT(deadband_hold_a, fire && in_dead && !step_wr, $stable(step_ff) && $stable(led_ff), "dead band changed the step or led")
   `ADSR_ASSERT_NOW(rsp_source_a, $rose(rsp_valid_ff), $past(avg_bus.valid), "result raised with no average ready")

endmodule
